@@ sv/dmqap_pkg.sv @@
// Shared constants for the DNS message query/answer parser.
package dmqap_pkg;

  // Parameter defaults
  localparam int MSG_BYTES_DEF = 512;
  localparam int NAME_LEN_DEF  = 64;

  // Offset arithmetic width: covers pointer targets and rdata + rdlength sums
  localparam int OFF_W = 18;

  // Header and name limits
  localparam int MAX_HOPS   = 20;
  localparam int MIN_HDR    = 12;
  localparam int MAX_QD     = 32;
  localparam int MAX_AN     = 64;
  localparam int HDR_BYTES  = 6;

  // Record types and codes
  localparam logic [15:0] TYPE_A    = 16'd1;
  localparam logic [15:0] TYPE_AAAA = 16'd28;
  localparam logic [15:0] RDLEN_A    = 16'd4;
  localparam logic [15:0] RDLEN_AAAA = 16'd16;
  localparam logic [3:0]  RCODE_NX  = 4'd3;
  localparam logic [7:0]  CHAR_DOT  = 8'd46;

  // Answer kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NX   = 2'd1;
  localparam logic [1:0] KIND_V4   = 2'd2;
  localparam logic [1:0] KIND_V6   = 2'd3;

endpackage

@@ sv/dmqap_ram.sv @@
// Generic single-port-write, registered-read RAM.
module dmqap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/dns_message_query_answer_parser_unit.sv @@
// DNS message parser: loads a message, then walks it in memory to emit the question name and summary.
//
// Bytes load at one per cycle into a message RAM of MSG_BYTES entries. After the byte marked
// end_of_msg, input stalls while a sequencer walks the stored message through the RAM's single
// registered read port, visiting stored bytes (header, names, pointers, record fields), then
// emits the question-name characters from a NAME_LEN-entry name RAM, then the summary. The
// summary is held in the output register while the next message loads. No clearing pass
// follows reset.
module dns_message_query_answer_parser_unit
  import dmqap_pkg::*;
#(
  parameter int MSG_BYTES = MSG_BYTES_DEF,
  parameter int NAME_LEN  = NAME_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        end_of_msg_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_summary_o,
  output logic [7:0]  name_char_o,
  output logic        valid_res_o,
  output logic        is_response_o,
  output logic [3:0]  resp_code_o,
  output logic [15:0] query_type_o,
  output logic [1:0]  answer_kind_o,
  output logic [63:0] addr_high_o,
  output logic [63:0] addr_low_o,
  output logic        run_last_o
);

  localparam int AW = $clog2(MSG_BYTES);
  localparam int CW = $clog2(MSG_BYTES + 1);
  localparam int NW = $clog2(NAME_LEN);

  // Sequencer states
  localparam logic [4:0] ST_LOAD  = 5'd0;
  localparam logic [4:0] ST_HDR   = 5'd1;
  localparam logic [4:0] ST_HCHK  = 5'd2;
  localparam logic [4:0] ND_CHK   = 5'd3;
  localparam logic [4:0] ND_TAG   = 5'd4;
  localparam logic [4:0] ND_PTR   = 5'd5;
  localparam logic [4:0] ND_LRD   = 5'd6;
  localparam logic [4:0] ND_LWR   = 5'd7;
  localparam logic [4:0] R16_A    = 5'd8;
  localparam logic [4:0] R16_B    = 5'd9;
  localparam logic [4:0] R16_C    = 5'd10;
  localparam logic [4:0] ST_QT    = 5'd11;
  localparam logic [4:0] ST_QTD   = 5'd12;
  localparam logic [4:0] ST_QLOOP = 5'd13;
  localparam logic [4:0] ST_QNX   = 5'd14;
  localparam logic [4:0] ST_ALOOP = 5'd15;
  localparam logic [4:0] ST_AN    = 5'd16;
  localparam logic [4:0] ST_AT    = 5'd17;
  localparam logic [4:0] ST_AL    = 5'd18;
  localparam logic [4:0] ST_RDA   = 5'd19;
  localparam logic [4:0] ST_RDB   = 5'd20;
  localparam logic [4:0] ST_ERD   = 5'd21;
  localparam logic [4:0] ST_ELD   = 5'd22;
  localparam logic [4:0] ST_SUM   = 5'd23;

  // Control registers
  logic [4:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          over_q, over_d;
  logic          out_valid_q, out_valid_d;

  // Parse registers
  logic [4:0]       ret_q, ret_d;
  logic [CW-1:0]    len_q, len_d;
  logic             ok_q, ok_d;
  logic [47:0]      hdr_q, hdr_d;
  logic [2:0]       hcnt_q, hcnt_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [OFF_W-1:0] resume_q, resume_d;
  logic [OFF_W-1:0] res_q, res_d;
  logic [OFF_W-1:0] noff_q, noff_d;
  logic [OFF_W-1:0] p_q, p_d;
  logic             jumped_q, jumped_d;
  logic [4:0]       hops_q, hops_d;
  logic             keep_q, keep_d;
  logic [5:0]       ptr_hi_q, ptr_hi_d;
  logic [6:0]       lab_q, lab_d;
  logic [NW-1:0]    used_q, used_d;
  logic [NW-1:0]    eidx_q, eidx_d;
  logic [15:0]      w_q, w_d;
  logic [15:0]      qtype_q, qtype_d;
  logic [15:0]      rtype_q, rtype_d;
  logic [5:0]       qi_q, qi_d;
  logic [6:0]       ai_q, ai_d;
  logic [4:0]       bcnt_q, bcnt_d;
  logic [1:0]       kind_q, kind_d;
  logic [127:0]     addr_q, addr_d;

  // Output payload registers
  logic        o_sum_q, o_sum_d;
  logic [7:0]  o_char_q, o_char_d;
  logic        o_vld_q, o_vld_d;
  logic        o_resp_q, o_resp_d;
  logic [3:0]  o_rcode_q, o_rcode_d;
  logic [15:0] o_qtype_q, o_qtype_d;
  logic [1:0]  o_kind_q, o_kind_d;
  logic [127:0] o_addr_q, o_addr_d;

  // Memory ports
  logic          msg_we, msg_re;
  logic [AW-1:0] msg_raddr;
  logic [7:0]    msg_rdata;
  logic          nm_we, nm_re;
  logic [NW-1:0] nm_waddr, nm_raddr;
  logic [7:0]    nm_wdata, nm_rdata;

  logic             in_fire, out_can_load;
  logic [OFF_W-1:0] len_w;
  logic [CW-1:0]    cnt_inc;
  logic [OFF_W-1:0] rdlen_end;
  logic             is_resp;
  logic [3:0]       rcode;
  logic [15:0]      qd, an;

  assign in_fire      = in_valid_i && !in_stall_o;
  assign in_stall_o   = (state_q != ST_LOAD);
  assign out_can_load = !out_valid_q || !out_stall_i;
  assign len_w        = OFF_W'(len_q);
  assign cnt_inc      = cnt_q + CW'(1);
  assign is_resp      = hdr_q[47];
  assign rcode        = hdr_q[35:32];
  assign qd           = hdr_q[31:16];
  assign an           = hdr_q[15:0];
  assign rdlen_end    = res_q + OFF_W'(10) + OFF_W'(w_q);

  assign msg_we = in_fire && (cnt_q < CW'(MSG_BYTES));

  dmqap_ram #(.WIDTH(8), .DEPTH(MSG_BYTES)) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (msg_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (msg_byte_i),
    .re_i    (msg_re),
    .raddr_i (msg_raddr),
    .rdata_o (msg_rdata)
  );

  dmqap_ram #(.WIDTH(8), .DEPTH(NAME_LEN)) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (nm_we),
    .waddr_i (nm_waddr),
    .wdata_i (nm_wdata),
    .re_i    (nm_re),
    .raddr_i (nm_raddr),
    .rdata_o (nm_rdata)
  );

  // Sequencer: load, parse header, decode names, scan answers, emit
  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  over_d = over_q;  out_valid_d = out_valid_q;
    ret_d = ret_q;  len_d = len_q;  ok_d = ok_q;  hdr_d = hdr_q;  hcnt_d = hcnt_q;
    off_d = off_q;  resume_d = resume_q;  res_d = res_q;  noff_d = noff_q;  p_d = p_q;
    jumped_d = jumped_q;  hops_d = hops_q;  keep_d = keep_q;  ptr_hi_d = ptr_hi_q;
    lab_d = lab_q;  used_d = used_q;  eidx_d = eidx_q;  w_d = w_q;  qtype_d = qtype_q;
    rtype_d = rtype_q;  qi_d = qi_q;  ai_d = ai_q;  bcnt_d = bcnt_q;  kind_d = kind_q;
    addr_d = addr_q;
    o_sum_d = o_sum_q;  o_char_d = o_char_q;  o_vld_d = o_vld_q;  o_resp_d = o_resp_q;
    o_rcode_d = o_rcode_q;  o_qtype_d = o_qtype_q;  o_kind_d = o_kind_q;  o_addr_d = o_addr_q;
    msg_re = 1'b0;  msg_raddr = off_q[AW-1:0];
    nm_we = 1'b0;  nm_waddr = used_q;  nm_wdata = msg_rdata;
    nm_re = 1'b0;  nm_raddr = eidx_q;

    // Drop the output item once transferred
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (cnt_q < CW'(MSG_BYTES)) begin
            cnt_d = cnt_inc;
          end else begin
            over_d = 1'b1;
          end
          if (end_of_msg_i) begin
            len_d   = (cnt_q < CW'(MSG_BYTES)) ? cnt_inc : cnt_q;
            cnt_d   = '0;
            over_d  = 1'b0;
            ok_d    = 1'b1;
            hcnt_d  = '0;
            used_d  = '0;
            eidx_d  = '0;
            kind_d  = KIND_NONE;
            qtype_d = '0;
            addr_d  = '0;
            if (over_q || cnt_q >= CW'(MSG_BYTES) ||
                ((cnt_q < CW'(MSG_BYTES)) ? cnt_inc : cnt_q) < CW'(MIN_HDR)) begin
              ok_d    = 1'b0;
              state_d = ST_SUM;
            end else begin
              state_d = ST_HDR;
            end
          end
        end
      end
      // Read flags, question and answer counts
      ST_HDR: begin
        if (hcnt_q < 3'(HDR_BYTES)) begin
          msg_re    = 1'b1;
          msg_raddr = AW'(hcnt_q) + AW'(2);
        end
        if (hcnt_q != '0) begin
          hdr_d = {hdr_q[39:0], msg_rdata};
        end
        hcnt_d = hcnt_q + 3'd1;
        if (hcnt_q == 3'(HDR_BYTES)) begin
          state_d = ST_HCHK;
        end
      end
      ST_HCHK: begin
        if (qd == '0 || qd > 16'(MAX_QD) || an > 16'(MAX_AN)) begin
          ok_d    = 1'b0;
          state_d = ST_SUM;
        end else begin
          off_d = OFF_W'(MIN_HDR);  keep_d = 1'b1;  jumped_d = 1'b0;  hops_d = '0;
          ret_d = ST_QT;  state_d = ND_CHK;
        end
      end
      // Name decoder
      ND_CHK: begin
        if (off_q >= len_w) begin
          state_d = keep_q ? ST_SUM : ST_ERD;
          if (keep_q) ok_d = 1'b0;
        end else begin
          msg_re  = 1'b1;
          state_d = ND_TAG;
        end
      end
      ND_TAG: begin
        if (msg_rdata[7:6] == 2'b11) begin
          if (off_q + OFF_W'(1) >= len_w) begin
            state_d = keep_q ? ST_SUM : ST_ERD;
            if (keep_q) ok_d = 1'b0;
          end else begin
            msg_re    = 1'b1;
            msg_raddr = AW'(off_q + OFF_W'(1));
            if (!jumped_q) resume_d = off_q + OFF_W'(2);
            ptr_hi_d = msg_rdata[5:0];
            state_d  = ND_PTR;
          end
        end else if (msg_rdata[7]) begin
          state_d = keep_q ? ST_SUM : ST_ERD;
          if (keep_q) ok_d = 1'b0;
        end else if (msg_rdata == 8'd0) begin
          res_d   = jumped_q ? resume_q : off_q + OFF_W'(1);
          state_d = ret_q;
        end else if (off_q + OFF_W'(1) + OFF_W'(msg_rdata) > len_w) begin
          state_d = keep_q ? ST_SUM : ST_ERD;
          if (keep_q) ok_d = 1'b0;
        end else if (keep_q) begin
          off_d = off_q + OFF_W'(1);
          lab_d = msg_rdata[6:0];
          if (used_q != '0 && used_q < NW'(NAME_LEN - 1)) begin
            nm_we    = 1'b1;
            nm_wdata = CHAR_DOT;
            used_d   = used_q + NW'(1);
          end
          state_d = ND_LRD;
        end else begin
          off_d   = off_q + OFF_W'(1) + OFF_W'(msg_rdata);
          state_d = ND_CHK;
        end
      end
      ND_PTR: begin
        off_d    = {{(OFF_W - 14){1'b0}}, ptr_hi_q, msg_rdata};
        jumped_d = 1'b1;
        hops_d   = hops_q + 5'd1;
        if (hops_q >= 5'(MAX_HOPS)) begin
          state_d = keep_q ? ST_SUM : ST_ERD;
          if (keep_q) ok_d = 1'b0;
        end else begin
          state_d = ND_CHK;
        end
      end
      ND_LRD: begin
        if (lab_q == '0) begin
          state_d = ND_CHK;
        end else if (used_q >= NW'(NAME_LEN - 1)) begin
          off_d   = off_q + OFF_W'(lab_q);
          lab_d   = '0;
          state_d = ND_CHK;
        end else begin
          msg_re  = 1'b1;
          state_d = ND_LWR;
        end
      end
      ND_LWR: begin
        nm_we   = 1'b1;
        used_d  = used_q + NW'(1);
        off_d   = off_q + OFF_W'(1);
        lab_d   = lab_q - 7'd1;
        state_d = ND_LRD;
      end
      // Big-endian 16-bit read at p
      R16_A: begin
        msg_re = 1'b1;  msg_raddr = AW'(p_q);  state_d = R16_B;
      end
      R16_B: begin
        msg_re = 1'b1;  msg_raddr = AW'(p_q + OFF_W'(1));
        w_d[15:8] = msg_rdata;  state_d = R16_C;
      end
      R16_C: begin
        w_d[7:0] = msg_rdata;  state_d = ret_q;
      end
      // First question type
      ST_QT: begin
        noff_d = res_q;
        if (res_q + OFF_W'(4) > len_w) begin
          ok_d = 1'b0;  state_d = ST_SUM;
        end else begin
          p_d = res_q;  ret_d = ST_QTD;  state_d = R16_A;
        end
      end
      ST_QTD: begin
        qtype_d = w_q;
        if (is_resp && rcode == RCODE_NX) begin
          kind_d = KIND_NX;  state_d = ST_ERD;
        end else if (is_resp && an != '0) begin
          off_d = noff_q + OFF_W'(4);  qi_d = 6'd1;  state_d = ST_QLOOP;
        end else begin
          state_d = ST_ERD;
        end
      end
      // Skip remaining questions
      ST_QLOOP: begin
        if (16'(qi_q) < qd) begin
          keep_d = 1'b0;  jumped_d = 1'b0;  hops_d = '0;
          ret_d = ST_QNX;  state_d = ND_CHK;
        end else begin
          ai_d = '0;  state_d = ST_ALOOP;
        end
      end
      ST_QNX: begin
        if (res_q + OFF_W'(4) > len_w) begin
          state_d = ST_ERD;
        end else begin
          off_d = res_q + OFF_W'(4);  qi_d = qi_q + 6'd1;  state_d = ST_QLOOP;
        end
      end
      // Scan answer records
      ST_ALOOP: begin
        if (16'(ai_q) < an) begin
          keep_d = 1'b0;  jumped_d = 1'b0;  hops_d = '0;
          ret_d = ST_AN;  state_d = ND_CHK;
        end else begin
          state_d = ST_ERD;
        end
      end
      ST_AN: begin
        if (res_q + OFF_W'(10) > len_w) begin
          state_d = ST_ERD;
        end else begin
          p_d = res_q;  ret_d = ST_AT;  state_d = R16_A;
        end
      end
      ST_AT: begin
        rtype_d = w_q;  p_d = res_q + OFF_W'(8);  ret_d = ST_AL;  state_d = R16_A;
      end
      ST_AL: begin
        if (rdlen_end > len_w) begin
          state_d = ST_ERD;
        end else if (rtype_q == TYPE_A && w_q == RDLEN_A) begin
          kind_d = KIND_V4;  bcnt_d = 5'(RDLEN_A);
          off_d = res_q + OFF_W'(10);  state_d = ST_RDA;
        end else if (rtype_q == TYPE_AAAA && w_q == RDLEN_AAAA) begin
          kind_d = KIND_V6;  bcnt_d = 5'(RDLEN_AAAA);
          off_d = res_q + OFF_W'(10);  state_d = ST_RDA;
        end else begin
          off_d = rdlen_end;  ai_d = ai_q + 7'd1;  state_d = ST_ALOOP;
        end
      end
      // Collect address bytes
      ST_RDA: begin
        msg_re = 1'b1;  off_d = off_q + OFF_W'(1);  state_d = ST_RDB;
      end
      ST_RDB: begin
        addr_d = {addr_q[119:0], msg_rdata};
        bcnt_d = bcnt_q - 5'd1;
        state_d = (bcnt_q == 5'd1) ? ST_ERD : ST_RDA;
      end
      // Emit name characters
      ST_ERD: begin
        if (eidx_q == used_q) begin
          state_d = ST_SUM;
        end else begin
          nm_re = 1'b1;  state_d = ST_ELD;
        end
      end
      ST_ELD: begin
        if (out_can_load) begin
          out_valid_d = 1'b1;
          o_sum_d = 1'b0;  o_char_d = nm_rdata;  o_vld_d = 1'b0;  o_resp_d = 1'b0;
          o_rcode_d = '0;  o_qtype_d = '0;  o_kind_d = KIND_NONE;  o_addr_d = '0;
          eidx_d  = eidx_q + NW'(1);
          state_d = ST_ERD;
        end
      end
      // Emit summary
      ST_SUM: begin
        if (out_can_load) begin
          out_valid_d = 1'b1;
          o_sum_d   = 1'b1;
          o_char_d  = '0;
          o_vld_d   = ok_q;
          o_resp_d  = ok_q && is_resp;
          o_rcode_d = ok_q ? rcode : 4'd0;
          o_qtype_d = ok_q ? qtype_q : 16'd0;
          o_kind_d  = ok_q ? kind_q : KIND_NONE;
          o_addr_d  = ok_q ? addr_q : 128'd0;
          state_d   = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      over_q      <= over_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
    end
  end

  // Parse and output payload
  always_ff @(posedge clk_i) begin
    ret_q <= ret_d;  len_q <= len_d;  ok_q <= ok_d;  hdr_q <= hdr_d;  hcnt_q <= hcnt_d;
    off_q <= off_d;  resume_q <= resume_d;  res_q <= res_d;  noff_q <= noff_d;  p_q <= p_d;
    jumped_q <= jumped_d;  hops_q <= hops_d;  keep_q <= keep_d;  ptr_hi_q <= ptr_hi_d;
    lab_q <= lab_d;  eidx_q <= eidx_d;  w_q <= w_d;  qtype_q <= qtype_d;
    rtype_q <= rtype_d;  qi_q <= qi_d;  ai_q <= ai_d;  bcnt_q <= bcnt_d;  kind_q <= kind_d;
    addr_q <= addr_d;
    o_sum_q <= o_sum_d;  o_char_q <= o_char_d;  o_vld_q <= o_vld_d;  o_resp_q <= o_resp_d;
    o_rcode_q <= o_rcode_d;  o_qtype_q <= o_qtype_d;  o_kind_q <= o_kind_d;
    o_addr_q <= o_addr_d;
  end

  assign out_valid_o   = out_valid_q;
  assign is_summary_o  = o_sum_q;
  assign name_char_o   = o_char_q;
  assign valid_res_o   = o_vld_q;
  assign is_response_o = o_resp_q;
  assign resp_code_o   = o_rcode_q;
  assign query_type_o  = o_qtype_q;
  assign answer_kind_o = o_kind_q;
  assign addr_high_o   = o_addr_q[127:64];
  assign addr_low_o    = o_addr_q[63:0];
  assign run_last_o    = o_sum_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MSG_BYTES)) else $error("byte count past store depth");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= NW'(NAME_LEN - 1)) else $error("name length past limit");
  a_bad_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_summary_o && !valid_res_o |-> answer_kind_o == KIND_NONE &&
    query_type_o == 16'd0) else $error("invalid summary carries answer");
  a_char_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_summary_o |-> !valid_res_o && answer_kind_o == KIND_NONE)
    else $error("name item carries summary fields");

endmodule
